/* design/mrls_pkg.sv */
package mrls_pkg;

   localparam int ACCEL_W = 12;
   localparam int MAG_W   = 24;
   localparam int BOUND_W = 21;
   localparam int DEN_W   = 19;
   localparam int QUOT_W  = 16;
   localparam int BR_W    = 17;
   localparam int PULSE_W = 7;
   localparam int STEP_W  = 4;
   localparam int TIMER_W = 13;
   localparam int LEVEL_W = 24;

   localparam logic [TIMER_W-1:0] TIMER_CAP   = 13'd4095;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 24'd995000;
   localparam logic [PULSE_W-1:0] PULSE_TOP   = 7'd100;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_SENSITIVITY    = 2'd0;
   localparam reg_index_type REG_RAMP_STEP      = 2'd1;
   localparam reg_index_type REG_HOLD_THRESHOLD = 2'd2;

   typedef logic [BOUND_W-1:0]       bound_type;
   typedef logic [PULSE_W-1:0]       pulse_type;
   typedef logic signed [STEP_W-1:0] step_type;

   function automatic bound_type min_of(input logic [3:0] sel);
      bound_type v;
      case (sel) inside
         4'd0, 4'd1, 4'd2: v = 21'd995000;
         4'd3, 4'd4, 4'd5: v = 21'd1070000;
         default:          v = 21'd1125000;
      endcase
      return v;
   endfunction

   function automatic bound_type max_of(input logic [3:0] sel);
      bound_type v;
      case (sel) inside
         4'd0:       v = 21'd1050000;
         4'd1, 4'd3: v = 21'd1100000;
         4'd2, 4'd4: v = 21'd1200000;
         4'd5, 4'd7: v = 21'd1300000;
         4'd6:       v = 21'd1150000;
         default:    v = 21'd1450000;
      endcase
      return v;
   endfunction

   function automatic pulse_type pulse_init(input int i);
      pulse_type v;
      case (i)
         0: v = 7'd88;   1: v = 7'd97;   2: v = 7'd10;   3: v = 7'd72;
         4: v = 7'd10;   5: v = 7'd62;   6: v = 7'd2;    7: v = 7'd29;
         8: v = 7'd79;   9: v = 7'd2;    10: v = 7'd62;  11: v = 7'd43;
         12: v = 7'd37;  13: v = 7'd48;  14: v = 7'd90;  15: v = 7'd9;
         16: v = 7'd45;  17: v = 7'd1;   18: v = 7'd36;  19: v = 7'd73;
         20: v = 7'd64;  21: v = 7'd17;  22: v = 7'd73;  23: v = 7'd38;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   function automatic step_type step_init(input int i);
      step_type v;
      case (i)
         0: v = -4'sd2;  1: v = 4'sd5;   2: v = -4'sd3;  3: v = -4'sd4;
         4: v = 4'sd3;   5: v = -4'sd2;  6: v = 4'sd3;   7: v = -4'sd5;
         8: v = -4'sd3;  9: v = 4'sd0;   10: v = -4'sd2; 11: v = 4'sd3;
         12: v = 4'sd5;  13: v = 4'sd3;  14: v = -4'sd5; 15: v = -4'sd1;
         16: v = -4'sd3; 17: v = 4'sd2;  18: v = 4'sd0;  19: v = -4'sd2;
         20: v = 4'sd3;  21: v = -4'sd1; 22: v = -4'sd5; 23: v = 4'sd1;
         default: v = 4'sd0;
      endcase
      return v;
   endfunction

endpackage

/* design/mrls_div.sv */
module mrls_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mrls_pkg::DEN_W-1:0]  num,
   input  logic [mrls_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [mrls_pkg::QUOT_W-1:0] quot
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic [mrls_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [mrls_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [mrls_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [mrls_pkg::DEN_W:0]    rem2;
   logic [mrls_pkg::DEN_W:0]    diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem2    = {rem_ff, 1'b0};
      diff    = rem2 - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd15;
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[mrls_pkg::DEN_W]) begin
            rem_in  = diff[mrls_pkg::DEN_W-1:0];
            quot_in = {quot_ff[mrls_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem2[mrls_pkg::DEN_W-1:0];
            quot_in = {quot_ff[mrls_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* design/motion_reactive_led_shader_top.sv */
// channel  dir  width  contents
// req      in   40     accel_x, accel_y, accel_z (12 bits signed each)
// rsp      out  32     led_index, red_level, green_level, blue_level; last_led on tlast
// csr      in   32     sensitivity @0x0, ramp_step @0x4, hold_threshold @0x8
//
// A request runs through three passes of the shared multiplier, a timer update,
// a level update and a ratio check, then the serial divider when the ratio lies
// strictly between zero and one, then a multiply step and an emit step per LED.
// req_tready is high only while the sequencer is idle.
// A stalled rsp holds the sequencer in its emit step.
// Synchronous reset loads initial values into control and LED state, not the datapath.
module motion_reactive_led_shader_top #(
   parameter int LED_COUNT = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // accel_x[11:0], accel_y[23:12], accel_z[35:24], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // led_index[4:0], red[12:5], green[19:13], blue[24:20], zeros
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [4:0] LAST_LED = 5'(LED_COUNT - 1);
   localparam logic [7:0] DIV10_MUL = 8'd205;

   typedef enum logic [2:0] {
      S_IDLE, S_SQUARE, S_TIMER, S_LEVEL, S_RATIO, S_DIVIDE, S_PULSE, S_EMIT
   } state_type;

   // configuration
   logic [3:0]  sens_ff;
   logic [11:0] ramp_ff;
   logic [8:0]  thr_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= 4'd0;
         ramp_ff <= 12'd100;
         thr_ff  <= 9'd50;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            mrls_pkg::REG_SENSITIVITY:    sens_ff <= csr_pwdata[3:0];
            mrls_pkg::REG_RAMP_STEP:      ramp_ff <= csr_pwdata[11:0];
            mrls_pkg::REG_HOLD_THRESHOLD: thr_ff  <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mrls_pkg::REG_SENSITIVITY:    csr_prdata = {28'd0, sens_ff};
         mrls_pkg::REG_RAMP_STEP:      csr_prdata = {20'd0, ramp_ff};
         mrls_pkg::REG_HOLD_THRESHOLD: csr_prdata = {23'd0, thr_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // datapath state
   state_type                   state_ff, state_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic [35:0]                 accel_ff, accel_in;
   logic [23:0]                 mag_ff, mag_in;
   logic signed [12:0]          timer_ff, timer_in;
   logic signed [23:0]          level_ff, level_in;
   logic [16:0]                 br_ff, br_in;
   logic [4:0]                  led_ff, led_in;
   logic [23:0]                 prod_ff, prod_in;
   mrls_pkg::pulse_type         pulse_ff [LED_COUNT];
   mrls_pkg::pulse_type         pulse_in [LED_COUNT];
   mrls_pkg::step_type          step_ff [LED_COUNT];
   mrls_pkg::step_type          step_in [LED_COUNT];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [24:0]                 rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   // shared multiplier
   logic [16:0]                 mul_a;
   logic [11:0]                 mul_b;
   logic [28:0]                 mul_p;

   logic [11:0]                 axis;
   logic [11:0]                 axis_abs;
   mrls_pkg::bound_type         lo, hi, den21;
   logic [12:0]                 cap;
   logic [12:0]                 ten_thr;
   logic signed [13:0]          timer14;
   logic signed [24:0]          lvl25, mag25, hi25, num25;
   logic                        div_start, div_done;
   logic [15:0]                 div_quot;
   logic [IDX_W-1:0]            idx;
   logic signed [7:0]           p_sum;
   mrls_pkg::pulse_type         p_new;
   mrls_pkg::step_type          s_cur, s_new;
   logic [24:0]                 red_full;
   logic [24:0]                 three_g;
   logic [16:0]                 blue_full;
   logic                        out_free;

   assign lo      = mrls_pkg::min_of(sens_ff);
   assign hi      = mrls_pkg::max_of(sens_ff);
   assign den21   = hi - lo;
   assign ten_thr = {1'b0, thr_ff, 3'b000} + {3'b000, thr_ff, 1'b0};
   assign cap     = (ten_thr > mrls_pkg::TIMER_CAP) ? mrls_pkg::TIMER_CAP : ten_thr;
   assign timer14 = {timer_ff[12], timer_ff};
   assign lvl25   = {level_ff[23], level_ff};
   assign mag25   = {1'b0, mag_ff};
   assign hi25    = {4'd0, hi};
   assign num25   = lvl25 - $signed({4'd0, lo});
   assign idx     = led_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cnt_ff)
         2'd0:    axis = accel_ff[11:0];
         2'd1:    axis = accel_ff[23:12];
         default: axis = accel_ff[35:24];
      endcase
   end
   assign axis_abs = axis[11] ? (~axis + 12'd1) : axis;

   assign s_cur = step_ff[idx];
   assign p_sum = $signed({1'b0, pulse_ff[idx]}) + 8'(s_cur);
   always_comb begin
      s_new = s_cur;
      p_new = p_sum[6:0];
      if (p_sum <= 8'sd0 && s_cur < 4'sd0) begin
         s_new = -s_cur;
         p_new = '0;
      end else if (p_sum >= 8'sd100 && s_cur > 4'sd0) begin
         s_new = -s_cur;
         p_new = mrls_pkg::PULSE_TOP;
      end
   end

   always_comb begin
      if (state_ff == S_SQUARE) begin
         mul_a = {5'd0, axis_abs};
         mul_b = axis_abs;
      end else begin
         mul_a = br_ff;
         mul_b = {5'd0, p_new};
      end
   end
   assign mul_p = mul_a * mul_b;

   assign red_full  = {br_ff, 8'd0} - {8'd0, br_ff};
   assign three_g   = {prod_ff, 1'b0} + {1'b0, prod_ff};
   assign blue_full = three_g[24:16] * DIV10_MUL;

   assign div_start = (state_ff == S_RATIO) && !num25[24] && (num25 != 25'sd0)
                      && (num25 < $signed({4'd0, den21}));

   mrls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num25[18:0]),
      .den   (den21[18:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      accel_in     = accel_ff;
      mag_in       = mag_ff;
      timer_in     = timer_ff;
      level_in     = level_ff;
      br_in        = br_ff;
      led_in       = led_ff;
      prod_in      = prod_ff;
      pulse_in     = pulse_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               accel_in = req_tdata[35:0];
               mag_in   = '0;
               cnt_in   = 2'd0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            mag_in = mag_ff + mul_p[23:0];
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = S_TIMER;
            end
         end
         S_TIMER: begin
            if (mag_ff <= {3'd0, lo} && timer_ff > 13'sd0) begin
               timer_in = timer_ff - 13'sd5;
            end else if (timer14 < $signed({1'b0, cap})) begin
               timer_in = timer_ff + 13'sd1;
            end
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            if (lvl25 < mag25 && lvl25 < hi25 && timer14 > $signed({5'd0, thr_ff})) begin
               level_in = level_ff + $signed({12'd0, ramp_ff});
            end else if (lvl25 > mag25) begin
               level_in = level_ff - $signed({12'd0, ramp_ff});
            end
            state_in = S_RATIO;
         end
         S_RATIO: begin
            led_in = '0;
            if (num25[24] || num25 == 25'sd0) begin
               br_in    = '0;
               state_in = S_PULSE;
            end else if (!div_start) begin
               br_in    = 17'h10000;
               state_in = S_PULSE;
            end else begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               br_in    = {1'b0, div_quot};
               state_in = S_PULSE;
            end
         end
         S_PULSE: begin
            pulse_in[idx] = p_new;
            step_in[idx]  = s_new;
            prod_in       = mul_p[23:0];
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {blue_full[15:11], prod_ff[22:16], red_full[23:16], led_ff};
               rsp_last_in  = (led_ff == LAST_LED);
               led_in       = led_ff + 5'd1;
               state_in     = (led_ff == LAST_LED) ? S_IDLE : S_PULSE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      accel_ff    <= accel_in;
      mag_ff      <= mag_in;
      br_ff       <= br_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         timer_ff     <= '0;
         level_ff     <= mrls_pkg::LEVEL_RESET;
         led_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            pulse_ff[i] <= mrls_pkg::pulse_init(i);
            step_ff[i]  <= mrls_pkg::step_init(i);
         end
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         level_ff     <= level_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
         pulse_ff     <= pulse_in;
         step_ff      <= step_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/mrls_checker.sv */
module mrls_checker #(
   parameter int LED_COUNT = 24
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   localparam logic [4:0] LAST_LED = 5'(LED_COUNT - 1);

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[4:0] == LAST_LED)))
      else $error("tlast does not match final LED");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:13] <= 7'd100) && (rsp_tdata[24:20] <= 5'd30))
      else $error("color channel out of range");

   a_next_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid
         || (rsp_tdata[4:0] == $past(rsp_tdata[4:0]) + 5'd1))
      else $error("LED index skipped");

endmodule

bind motion_reactive_led_shader_top mrls_checker #(.LED_COUNT(LED_COUNT)) u_mrls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* verif/led_color_checker.sv */
`timescale 1ns / 1ps

module led_color_checker
   import mrls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          colors_due
);

   localparam int LED_COUNT = 24;
   localparam int Q_ONE     = 65536;
   localparam int TIMER_TOP = 4095;

   // LED 0 in the lowest bits
   localparam logic [24*7-1:0] PULSE_START = {
      7'd38, 7'd73, 7'd17, 7'd64, 7'd73, 7'd36, 7'd1,  7'd45, 7'd9,  7'd90, 7'd48, 7'd37,
      7'd43, 7'd62, 7'd2,  7'd79, 7'd29, 7'd2,  7'd62, 7'd10, 7'd72, 7'd10, 7'd97, 7'd88};
   localparam logic [24*4-1:0] STEP_START = {
      4'sd1,  -4'sd5, -4'sd1, 4'sd3,  -4'sd2, 4'sd0,  4'sd2,  -4'sd3,
      -4'sd1, -4'sd5, 4'sd3,  4'sd5,  4'sd3,  -4'sd2, 4'sd0,  -4'sd3,
      -4'sd5, 4'sd3,  -4'sd2, 4'sd3,  -4'sd4, -4'sd3, 4'sd5,  -4'sd2};

   typedef struct packed {
      logic [4:0] led_index;
      logic [7:0] red;
      logic [6:0] green;
      logic [4:0] blue;
      logic       last_led;
   } led_color_t;

   led_color_t colors_expected [$];

   int sensitivity;
   int ramp;
   int threshold;
   int hold_timer;
   int level;
   int pulse     [LED_COUNT];
   int pulse_dir [LED_COUNT];

   initial error_count = 0;

   function automatic int quiet_bound(input int sel);
      case (sel)
         0, 1, 2: return 995000;
         3, 4, 5: return 1070000;
         default: return 1125000;
      endcase
   endfunction

   function automatic int full_bound(input int sel);
      case (sel)
         0:       return 1050000;
         1, 3:    return 1100000;
         2, 4:    return 1200000;
         5, 7:    return 1300000;
         6:       return 1150000;
         default: return 1450000;
      endcase
   endfunction

   task automatic predict_tick(input logic [39:0] sample);
      int ax, ay, az, mag, sel, lo, hi, cap, p;
      longint num, span, br;
      led_color_t c;
      ax = $signed(sample[11:0]);
      ay = $signed(sample[23:12]);
      az = $signed(sample[35:24]);
      mag = ax * ax + ay * ay + az * az;
      sel = (sensitivity > 8) ? 8 : sensitivity;
      lo = quiet_bound(sel);
      hi = full_bound(sel);
      cap = (10 * threshold > TIMER_TOP) ? TIMER_TOP : 10 * threshold;

      if (mag <= lo && hold_timer > 0) hold_timer -= 5;
      else if (hold_timer < cap) hold_timer += 1;

      if (level < mag && level < hi && hold_timer > threshold) level += ramp;
      else if (level > mag) level -= ramp;

      num  = level - lo;
      span = hi - lo;
      if (num <= 0) br = 0;
      else if (num >= span) br = Q_ONE;
      else br = (num * Q_ONE) / span;

      for (int j = 0; j < LED_COUNT; j++) begin
         p = pulse[j] + pulse_dir[j];
         if (p <= 0 && pulse_dir[j] < 0) begin
            pulse_dir[j] = -pulse_dir[j];
            p = 0;
         end else if (p >= 100 && pulse_dir[j] > 0) begin
            pulse_dir[j] = -pulse_dir[j];
            p = 100;
         end
         pulse[j] = p;
         c.led_index = j[4:0];
         c.red       = (255 * br) / Q_ONE;
         c.green     = (br * p) / Q_ONE;
         c.blue      = (30 * br * p) / (100 * Q_ONE);
         c.last_led  = (j == LED_COUNT - 1);
         colors_expected.push_back(c);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_color(input logic [31:0] data, input logic last);
      led_color_t want;
      if (colors_expected.size() == 0) begin
         $error("LED color with no request pending: data %h", data);
         error_count++;
      end else begin
         want = colors_expected.pop_front();
         compare_field("led_index", want.led_index, data[4:0]);
         compare_field("red_level", want.red, data[12:5]);
         compare_field("green_level", want.green, data[19:13]);
         compare_field("blue_level", want.blue, data[24:20]);
         compare_field("last_led", want.last_led, last);
         compare_field("tdata padding", 0, data[31:25]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sensitivity = 0;
         ramp        = 100;
         threshold   = 50;
         hold_timer  = 0;
         level       = 995000;
         for (int j = 0; j < LED_COUNT; j++) begin
            pulse[j]     = PULSE_START[j*7 +: 7];
            pulse_dir[j] = $signed(STEP_START[j*4 +: 4]);
         end
         colors_expected.delete();
      end else begin
         // results first: a new request can be accepted on the edge of the last color
         if (rsp_tvalid && rsp_tready) check_color(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) predict_tick(req_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SENSITIVITY:    sensitivity = csr_pwdata[3:0];
               REG_RAMP_STEP:      ramp        = csr_pwdata[11:0];
               REG_HOLD_THRESHOLD: threshold   = csr_pwdata[8:0];
               default: ;
            endcase
         end
      end
      colors_due <= colors_expected.size();
   end

endmodule

/* verif/motion_reactive_led_shader_top_test.sv */
`timescale 1ns / 1ps

module motion_reactive_led_shader_top_test;
   import mrls_pkg::*;

   typedef enum {SHAKE, BAND, REST, NOISE} motion_kind_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // accel_x, accel_y, accel_z, zeros
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // led_index, red, green, blue, zeros
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int           error_count;
   int           colors_due;
   motion_kind_e motion = BAND;
   int           episode_left = 0;
   bit           sender_steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   motion_reactive_led_shader_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   led_color_checker color_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .colors_due  (colors_due)
   );

   task automatic send_sample(input logic [11:0] ax, input logic [11:0] ay,
                              input logic [11:0] az);
      int gap;
      if ($urandom_range(0, 29) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {4'b0, az, ay, ax};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   function automatic logic [11:0] signed_axis(input int lo, input int hi);
      int m;
      m = $urandom_range(lo, hi);
      if ($urandom_range(0, 1)) m = -m;
      return m[11:0];
   endfunction

   // episodes of one kind of motion so the hold timer and level get somewhere
   task automatic send_motion;
      logic [11:0] axis [3];
      int roll, dom;
      if (episode_left == 0) begin
         roll = $urandom_range(0, 99);
         motion = (roll < 40) ? BAND : (roll < 65) ? SHAKE : (roll < 85) ? REST : NOISE;
         episode_left = $urandom_range(3, 30);
      end
      episode_left--;
      dom = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         case (motion)
            SHAKE:   axis[i] = signed_axis(1200, 2047);
            BAND:    axis[i] = (i == dom) ? signed_axis(950, 1210) : signed_axis(0, 250);
            REST:    axis[i] = signed_axis(0, 500);
            default: axis[i] = $urandom_range(0, 4095);
         endcase
      end
      send_sample(axis[0], axis[1], axis[2]);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (colors_due != 0) @(posedge clock);
   endtask

   task automatic run_phase(input logic [3:0] sens, input logic [11:0] ramp,
                            input logic [8:0] thr, input int count);
      wait_for_drain();
      write_csr(REG_SENSITIVITY, sens);
      write_csr(REG_RAMP_STEP, ramp);
      write_csr(REG_HOLD_THRESHOLD, thr);
      repeat (count) send_motion();
   endtask

   initial begin : receiver
      int stall, taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 17);
         // long hold-off so the block backs up and stalls its request side
         if (taken == 150) stall = 600;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         taken++;
      end
   end

   initial begin : stimulus
      logic [3:0]  sens;
      logic [11:0] ramp;
      logic [8:0]  thr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes, then timer undershoot down to -2 and -4
      send_sample(2047, 2047, 2047);
      send_sample(-2048, -2048, -2048);
      send_sample(-2048, 0, 0);
      repeat (5) send_sample(0, 0, 0);
      send_sample(-1, -1, -1);
      send_sample(1, 1, 1);
      send_sample(2047, 0, 0);
      send_sample(0, 2047, 0);
      send_sample(0, 0, 2047);
      send_sample(0, -2048, 0);
      send_sample(0, 0, -2048);
      send_sample(997, 0, 0);
      send_sample(998, 0, 0);
      send_sample(1025, 0, 0);
      send_sample(-1204, 0, 0);
      send_sample(0, 1205, 0);

      run_phase(4'd0, 12'd4095, 9'd1, 40);
      run_phase(4'd8, 12'd2500, 9'd4, 40);
      run_phase(4'd15, 12'd1800, 9'd0, 30);   // zero threshold, sensitivity saturates
      run_phase(4'd2, 12'd0, 9'd3, 15);       // zero ramp
      run_phase(4'd9, 12'd4095, 9'd409, 25);
      run_phase(4'd4, 12'd1, 9'd511, 15);     // timer cap below 10*threshold
      run_phase(4'd6, 12'd3000, 9'd2, 30);
      repeat (8) begin
         sens = $urandom_range(0, 15);
         ramp = $urandom_range(0, 1) ? $urandom_range(1000, 4095) : $urandom_range(0, 4095);
         thr  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 20) : $urandom_range(0, 511);
         run_phase(sens, ramp, thr, 26);
      end

      wait_for_drain();
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
